// ===== sv/smo_pkg.sv =====
`default_nettype none

package smo_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FC_W   = 17;
    localparam int unsigned ACC_W  = 50;
    localparam int unsigned OPR_W  = 33;
    localparam int unsigned PROD_W = 2 * OPR_W;
    localparam int unsigned Q_FRAC = 16;

    typedef logic signed [DATA_W-1:0] t_q;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [OPR_W-1:0]  t_opr;
    typedef logic signed [PROD_W-1:0] t_prod;

    // register indexes of the configuration port
    localparam logic [2:0] REG_COEF_A      = 3'd0;
    localparam logic [2:0] REG_COEF_B      = 3'd1;
    localparam logic [2:0] REG_GAIN_RATIO  = 3'd2;
    localparam logic [2:0] REG_SWITCH_GAIN = 3'd3;
    localparam logic [2:0] REG_FILTER_COEF = 3'd4;

    localparam t_acc SAT_MAX = t_acc'(64'sh0000_0000_7FFF_FFFF);
    localparam t_acc SAT_MIN = t_acc'(-64'sh0000_0000_8000_0000);

    function automatic t_acc sext(input t_q v);
        sext = {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic t_q sat32(input t_acc v);
        if (v > SAT_MAX) begin
            sat32 = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            sat32 = SAT_MIN[DATA_W-1:0];
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    // Q16.16 product rounded half up; floor comes from dropping the low bits
    function automatic t_acc qround(input t_prod p);
        t_prod t;
        t = p + t_prod'(1 << (Q_FRAC - 1));
        qround = t[PROD_W-1:Q_FRAC];
    endfunction

    function automatic t_acc sgn_gain(input t_q v, input t_q eta);
        if (v == '0) begin
            sgn_gain = '0;
        end else if (v[DATA_W-1]) begin
            sgn_gain = -sext(eta);
        end else begin
            sgn_gain = sext(eta);
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/sliding_mode_back_emf_observer.sv =====
`default_nettype none

// Sliding mode back-EMF observer. Each input word carries measured alpha/beta
// currents and applied voltages (Q16.16); each output word carries the
// low-pass filtered alpha/beta back-EMF estimate (Q16.16, saturated). One
// 33x33 multiplier, registered, is shared by all twelve products of a sample
// under a step sequencer: ten steps per axis, two axes. The input is not ready
// while a sample is being processed. A finished word waits in the output
// register while the next sample is accepted; the last step stalls only if
// the previous word has still not been taken. Coefficients are written
// through the cfg channel, which is always ready.
module sliding_mode_back_emf_observer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // [31:0] i_alpha, [63:32] i_beta, [95:64] u_alpha, [127:96] u_beta
    input  wire logic [127:0] s_axis_tdata,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] emf_alpha, [63:32] emf_beta
    output      logic [63:0]  m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output      logic         o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [3:0] STEP_ERR    = 4'd0;
    localparam logic [3:0] STEP_BU     = 4'd1;
    localparam logic [3:0] STEP_BE     = 4'd2;
    localparam logic [3:0] STEP_APE    = 4'd3;
    localparam logic [3:0] STEP_NEWI   = 4'd4;
    localparam logic [3:0] STEP_INNER  = 4'd5;
    localparam logic [3:0] STEP_GAIN   = 4'd6;
    localparam logic [3:0] STEP_NEWE   = 4'd7;
    localparam logic [3:0] STEP_FILT   = 4'd8;
    localparam logic [3:0] STEP_UPDATE = 4'd9;

    logic                 r_state, n_state;
    logic [3:0]           r_step, n_step;
    logic                 r_axis, n_axis;
    logic                 r_out_valid;
    logic [63:0]          r_out_data;
    logic [127:0]         r_in;

    smo_pkg::t_q          r_coef_a, r_coef_b, r_gain_ratio, r_switch_gain;
    logic [16:0]          r_filter_coef;

    smo_pkg::t_q          r_est_cur [2];
    smo_pkg::t_q          r_est_emf [2];
    smo_pkg::t_q          r_prev_err [2];
    smo_pkg::t_q          r_prev_filt [2];

    smo_pkg::t_q          r_err;
    smo_pkg::t_q          r_new_i;
    smo_pkg::t_acc        r_acc, n_acc;
    smo_pkg::t_prod       r_prod;

    smo_pkg::t_opr        w_opx, w_opy;
    smo_pkg::t_acc        w_q;
    smo_pkg::t_q          w_i_meas, w_u_app, w_ec, w_ee, w_pe, w_pf, w_filt;
    logic                 w_last;
    logic                 w_advance;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    assign w_i_meas = r_axis ? r_in[63:32]  : r_in[31:0];
    assign w_u_app  = r_axis ? r_in[127:96] : r_in[95:64];
    assign w_ec     = r_est_cur[r_axis];
    assign w_ee     = r_est_emf[r_axis];
    assign w_pe     = r_prev_err[r_axis];
    assign w_pf     = r_prev_filt[r_axis];
    assign w_q      = smo_pkg::qround(r_prod);
    assign w_filt   = smo_pkg::sat32(smo_pkg::sext(w_pf) + w_q);

    assign w_last    = (r_step == STEP_UPDATE) && r_axis;
    // hold the last step while the previous word is still unread
    assign w_advance = !w_last || !r_out_valid || m_axis_tready;

    // operand select for the shared multiplier
    always_comb begin
        w_opx = '0;
        w_opy = '0;
        case (r_step)
            STEP_ERR: begin
                w_opx = smo_pkg::t_opr'(r_coef_a);
                w_opy = smo_pkg::t_opr'(w_ec);
            end
            STEP_BU: begin
                w_opx = smo_pkg::t_opr'(r_coef_b);
                w_opy = smo_pkg::t_opr'(w_u_app);
            end
            STEP_BE: begin
                w_opx = smo_pkg::t_opr'(r_coef_b);
                w_opy = smo_pkg::t_opr'(w_ee);
            end
            STEP_APE: begin
                w_opx = smo_pkg::t_opr'(r_coef_a);
                w_opy = smo_pkg::t_opr'(w_pe);
            end
            STEP_GAIN: begin
                w_opx = smo_pkg::t_opr'(r_gain_ratio);
                w_opy = smo_pkg::t_opr'($signed(r_acc[31:0]));
            end
            // keep the filter product alive while the last step is held
            STEP_FILT, STEP_UPDATE: begin
                w_opx = smo_pkg::t_opr'({1'b0, r_filter_coef});
                w_opy = smo_pkg::t_opr'($signed(r_acc[31:0])) - smo_pkg::t_opr'(w_pf);
            end
            default: begin
                w_opx = '0;
                w_opy = '0;
            end
        endcase
    end

    always_comb begin
        n_acc = r_acc;
        case (r_step)
            STEP_BU:    n_acc = w_q;
            STEP_BE:    n_acc = r_acc + w_q;
            STEP_APE:   n_acc = r_acc - w_q;
            STEP_NEWI:  n_acc = smo_pkg::sext(r_err) - w_q
                                + smo_pkg::sgn_gain(w_pe, r_switch_gain);
            STEP_INNER: n_acc = smo_pkg::sext(smo_pkg::sat32(r_acc));
            STEP_NEWE:  n_acc = smo_pkg::sext(smo_pkg::sat32(smo_pkg::sext(w_ee) + w_q));
            default:    n_acc = r_acc;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_axis  = r_axis;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_RUN;
                    n_step  = STEP_ERR;
                    n_axis  = 1'b0;
                end
            end
            ST_RUN: begin
                if (r_step == STEP_UPDATE) begin
                    if (w_advance) begin
                        n_step = STEP_ERR;
                        n_axis = !r_axis;
                        if (r_axis) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = STEP_ERR;
                n_axis  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_ERR;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_axis  <= n_axis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a      <= '0;
            r_coef_b      <= '0;
            r_gain_ratio  <= '0;
            r_switch_gain <= '0;
            r_filter_coef <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                smo_pkg::REG_COEF_A:      r_coef_a      <= i_cfg_data;
                smo_pkg::REG_COEF_B:      r_coef_b      <= i_cfg_data;
                smo_pkg::REG_GAIN_RATIO:  r_gain_ratio  <= i_cfg_data;
                smo_pkg::REG_SWITCH_GAIN: r_switch_gain <= i_cfg_data;
                smo_pkg::REG_FILTER_COEF: r_filter_coef <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_opx * w_opy;
        r_acc  <= n_acc;
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata;
        end
        if (r_state == ST_RUN && r_step == STEP_ERR) begin
            r_err <= smo_pkg::sat32(smo_pkg::sext(w_ec) - smo_pkg::sext(w_i_meas));
        end
        if (r_state == ST_RUN && r_step == STEP_NEWI) begin
            r_new_i <= smo_pkg::sat32(r_acc - smo_pkg::sgn_gain(r_err, r_switch_gain));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_est_cur[k]   <= '0;
                r_est_emf[k]   <= '0;
                r_prev_err[k]  <= '0;
                r_prev_filt[k] <= '0;
            end
        end else if (r_state == ST_RUN && r_step == STEP_UPDATE && w_advance) begin
            r_est_cur[r_axis]   <= r_new_i;
            r_est_emf[r_axis]   <= r_acc[31:0];
            r_prev_err[r_axis]  <= r_err;
            r_prev_filt[r_axis] <= w_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RUN && w_last && w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && w_last && w_advance) begin
            r_out_data <= {w_filt, r_prev_filt[0]};
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready while a sample is in progress");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_UPDATE)
        else $error("sequencer step out of range");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_step == STEP_ERR && !r_axis)
        else $error("sequencer not parked while idle");

    a_word_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_state == ST_IDLE && $past(r_state) == ST_RUN)
        else $error("output word produced outside the last step");
`endif

endmodule

`default_nettype wire
